>>> hdl/sorted_priority_queue_core_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, masked during reset
`define SPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset
`define SPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/spq_pkg.sv
// Package of the sorted priority queue: sizes, codes and the
// controller/datapath interface structs. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int PRIO_BITS   = 4;
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    push;
    logic    pop;
    logic    emit;
    status_t code;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic req_pop;
    logic empty;
    logic full;
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/spq_ctrl.sv
// Controller of the sorted priority queue: accepts a command beat, then
// decides push, pop or reject in the execute cycle. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  output logic           busy,
  input  spq_pkg::stat_t stat,
  output spq_pkg::ctrl_t ctl
);
  import spq_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.code   = ST_DONE;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.emit   = 1'b1;
        state_next = S_IDLE;
        if (stat.req_pop) begin
          if (stat.empty) begin
            ctl.code = ST_EMPTY;
          end else begin
            ctl.pop = 1'b1;
          end
        end else begin
          if (stat.full) begin
            ctl.code = ST_FULL;
          end else begin
            ctl.push = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/spq_datapath.sv
// Datapath of the sorted priority queue: request latch, sorted slot row
// with per-slot insert/shift logic, count and result registers.
// Depends on spq_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_core_macros.svh"

module spq_datapath (
  input  wire                             clk,
  input  wire                             rst,
  input  spq_pkg::ctrl_t                  ctl,
  output spq_pkg::stat_t                  stat,
  input  wire                             cmd,
  input  wire  [spq_pkg::PRIO_BITS-1:0]   priority_req,
  input  wire  [spq_pkg::TAG_BITS-1:0]    msg_tag,
  output logic                            done,
  output logic                            out_valid,
  output logic [spq_pkg::PRIO_BITS-1:0]   out_priority,
  output logic [spq_pkg::TAG_BITS-1:0]    out_tag,
  output logic [1:0]                      status,
  output logic [spq_pkg::COUNT_BITS-1:0]  entry_count
);
  import spq_pkg::*;

  logic                  req_cmd;
  logic [PRIO_BITS-1:0]  req_prio;
  logic [TAG_BITS-1:0]   req_tag;

  logic [PRIO_BITS-1:0]  slot_priority [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]   slot_tag      [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [QUEUE_DEPTH-1:0] keep;

  // Latch the request beat
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd  <= cmd;
      req_prio <= priority_req;
      req_tag  <= msg_tag;
    end
  end

  assign stat.req_pop = (req_cmd == CMD_POP);
  assign stat.empty   = (count == '0);
  assign stat.full    = (count == COUNT_BITS'(QUEUE_DEPTH));

  // Mark slots that stay ahead of a new entry (occupied, priority >= new)
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep[i] = (COUNT_BITS'(i) < count) && (slot_priority[i] >= req_prio);
    end
  end

  // Per-slot update: hold, take the new entry, shift down on push, shift up on pop
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (ctl.push && !keep[i]) begin
        if (i == 0) begin
          slot_priority[i] <= req_prio;
          slot_tag[i]      <= req_tag;
        end else if (keep[(i == 0) ? 0 : i - 1]) begin
          slot_priority[i] <= req_prio;
          slot_tag[i]      <= req_tag;
        end else begin
          slot_priority[i] <= slot_priority[(i == 0) ? 0 : i - 1];
          slot_tag[i]      <= slot_tag[(i == 0) ? 0 : i - 1];
        end
      end else if (ctl.pop && (i < QUEUE_DEPTH - 1)) begin
        slot_priority[i] <= slot_priority[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        slot_tag[i]      <= slot_tag[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Advance the entry count
  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + 1'b1;
    end else if (ctl.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= ctl.emit;
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_valid    <= ctl.pop;
      out_priority <= ctl.pop ? slot_priority[0] : '0;
      out_tag      <= ctl.pop ? slot_tag[0] : '0;
      status       <= ctl.code;
      entry_count  <= count_next;
    end
  end

  `SPQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= COUNT_BITS'(QUEUE_DEPTH), "count over depth")
  `SPQ_ASSERT_IMP(a_push_room, clk, rst, ctl.push, !stat.full, "push into full queue")
  `SPQ_ASSERT_NXT(a_pop_count, clk, rst, ctl.pop, count == $past(count) - 1'b1, "pop count slip")
  `SPQ_ASSERT_IMP(a_empty_zero, clk, rst, done && status == ST_EMPTY, entry_count == '0 && !out_valid, "empty result not clean")

endmodule

`default_nettype wire

>>> hdl/sorted_priority_queue_core.sv
// Sorted priority queue of 16 tagged entries. A command beat is taken when
// start is high and busy low; it is latched, then the execute state inserts into
// or shifts the slot row and its result beat is registered onto done. No new
// command is taken while busy. The receiver cannot stall; each result stands for one cycle.
// Synchronous reset empties the queue; slot contents are left as they were.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_core (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire                             cmd,
  input  wire  [spq_pkg::PRIO_BITS-1:0]   priority_req,
  input  wire  [spq_pkg::TAG_BITS-1:0]    msg_tag,
  output logic                            done,
  output logic                            out_valid,
  output logic [spq_pkg::PRIO_BITS-1:0]   out_priority,
  output logic [spq_pkg::TAG_BITS-1:0]    out_tag,
  output logic [1:0]                      status,
  output logic [spq_pkg::COUNT_BITS-1:0]  entry_count
);
  import spq_pkg::*;

  ctrl_t ctl;
  stat_t stat;

  // Sequence each command beat
  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  // Hold the sorted entries and build the result beat
  spq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .cmd          (cmd),
    .priority_req (priority_req),
    .msg_tag      (msg_tag),
    .done         (done),
    .out_valid    (out_valid),
    .out_priority (out_priority),
    .out_tag      (out_tag),
    .status       (status),
    .entry_count  (entry_count)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_sorted_priority_queue_core.sv
// Self-checking testbench of sorted_priority_queue_core: a directed table, then
// random push/pop traffic checked against a sorted-list model of the queue.
// Depends on spq_pkg and the sorted_priority_queue_core RTL.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIRECTED  = 22;
  localparam int PHASE_BEATS = 455;
  localparam int N_PHASES    = 4;

  // One popped or reported result beat, field by field
  typedef struct packed {
    logic                  vld;
    logic [PRIO_BITS-1:0]  prio;
    logic [TAG_BITS-1:0]   tag;
    status_t               st;
    logic [COUNT_BITS-1:0] cnt;
  } queue_result_t;

  // One directed command; typed marks a row whose result is written out here
  typedef struct packed {
    cmd_t                 op;
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
    logic                 typed;
    queue_result_t        res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  cmd = CMD_PUSH;
  logic [PRIO_BITS-1:0]  priority_req = '0;
  logic [TAG_BITS-1:0]   msg_tag = '0;
  logic                  busy;
  logic                  done;
  logic                  out_valid;
  logic [PRIO_BITS-1:0]  out_priority;
  logic [TAG_BITS-1:0]   out_tag;
  logic [1:0]            status;
  logic [COUNT_BITS-1:0] entry_count;

  // Side channel that travels with each beat: a typed expectation, if any
  logic                  row_typed = 1'b0;
  queue_result_t         row_res = '0;

  // Model of the slot row
  logic [PRIO_BITS-1:0]  model_prio [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]   model_tag [QUEUE_DEPTH];
  int                    model_count = 0;

  queue_result_t         pending_results [$];
  int                    sent_count = 0;
  int                    got_count = 0;
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  int                    idle_pct = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_POP,  4'd0,  16'h0000, 1'b1, '{1'b0, 4'd0, 16'h0000, ST_EMPTY, 5'd0}},
    '{CMD_PUSH, 4'd15, 16'hffff, 1'b1, '{1'b0, 4'd0, 16'h0000, ST_DONE, 5'd1}},
    '{CMD_POP,  4'd0,  16'h0000, 1'b1, '{1'b1, 4'd15, 16'hffff, ST_DONE, 5'd0}},
    '{CMD_PUSH, 4'd7,  16'haaaa, 1'b0, '0},
    '{CMD_PUSH, 4'd7,  16'h5555, 1'b0, '0},
    '{CMD_PUSH, 4'd0,  16'h0000, 1'b0, '0},
    '{CMD_PUSH, 4'd15, 16'h0001, 1'b0, '0},
    '{CMD_PUSH, 4'd3,  16'h8000, 1'b0, '0},
    '{CMD_PUSH, 4'd7,  16'h0f0f, 1'b0, '0},
    '{CMD_PUSH, 4'd0,  16'hffff, 1'b0, '0},
    '{CMD_PUSH, 4'd12, 16'h1234, 1'b0, '0},
    '{CMD_PUSH, 4'd1,  16'h4321, 1'b0, '0},
    '{CMD_PUSH, 4'd15, 16'h0002, 1'b0, '0},
    '{CMD_PUSH, 4'd8,  16'h00ff, 1'b0, '0},
    '{CMD_PUSH, 4'd3,  16'hff00, 1'b0, '0},
    '{CMD_PUSH, 4'd10, 16'hc3c3, 1'b0, '0},
    '{CMD_PUSH, 4'd10, 16'h3c3c, 1'b0, '0},
    '{CMD_PUSH, 4'd5,  16'h7777, 1'b0, '0},
    '{CMD_PUSH, 4'd14, 16'hfffe, 1'b0, '0},
    '{CMD_PUSH, 4'd9,  16'hbeef, 1'b1, '{1'b0, 4'd0, 16'h0000, ST_FULL, 5'd16}},
    '{CMD_POP,  4'd15, 16'hffff, 1'b0, '0},
    '{CMD_POP,  4'd0,  16'h0000, 1'b0, '0}
  };

  sorted_priority_queue_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .priority_req (priority_req),
    .msg_tag      (msg_tag),
    .done         (done),
    .out_valid    (out_valid),
    .out_priority (out_priority),
    .out_tag      (out_tag),
    .status       (status),
    .entry_count  (entry_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[tb] cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Apply one command to the model and return the result it gives
  function automatic queue_result_t queue_step(input cmd_t op,
                                               input logic [PRIO_BITS-1:0] p,
                                               input logic [TAG_BITS-1:0] t);
    queue_result_t r;
    int pos;
    int i;
    r = '0;
    r.st = ST_DONE;
    if (op == CMD_PUSH) begin
      if (model_count >= QUEUE_DEPTH) begin
        r.st = ST_FULL;
      end else begin
        // go behind every entry of greater or equal priority
        pos = 0;
        while (pos < model_count && model_prio[pos] >= p) pos++;
        for (i = model_count; i > pos; i--) begin
          model_prio[i] = model_prio[i-1];
          model_tag[i]  = model_tag[i-1];
        end
        model_prio[pos] = p;
        model_tag[pos]  = t;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        r.st = ST_EMPTY;
      end else begin
        r.vld  = 1'b1;
        r.prio = model_prio[0];
        r.tag  = model_tag[0];
        for (i = 1; i < model_count; i++) begin
          model_prio[i-1] = model_prio[i];
          model_tag[i-1]  = model_tag[i];
        end
        model_count--;
      end
    end
    r.cnt = COUNT_BITS'(model_count);
    return r;
  endfunction

  task automatic compare_result(input queue_result_t want, input queue_result_t got);
    if (got.vld !== want.vld)
      report_mismatch($sformatf("out_valid %b, want %b", got.vld, want.vld));
    if (got.prio !== want.prio)
      report_mismatch($sformatf("out_priority %0d, want %0d", got.prio, want.prio));
    if (got.tag !== want.tag)
      report_mismatch($sformatf("out_tag %h, want %h", got.tag, want.tag));
    if (got.st !== want.st)
      report_mismatch($sformatf("status %0d, want %0d", got.st, want.st));
    if (got.cnt !== want.cnt)
      report_mismatch($sformatf("entry_count %0d, want %0d", got.cnt, want.cnt));
  endtask

  // Predict on every accepted beat, then check any result beat of this cycle
  always @(posedge clk) begin
    queue_result_t predicted;
    queue_result_t seen;
    cycle_count++;
    if (!rst) begin
      if (start && !busy) begin
        predicted = queue_step(cmd_t'(cmd), priority_req, msg_tag);
        pending_results.push_back(row_typed ? row_res : predicted);
      end
      if (done) begin
        seen = '{out_valid, out_priority, out_tag, status_t'(status), entry_count};
        got_count++;
        if (pending_results.size() == 0)
          report_mismatch("result beat with nothing pending");
        else
          compare_result(pending_results.pop_front(), seen);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_priority_queue_core: mismatch");
      $finish;
    end
  end

  // Offer one command beat, idling first as the phase asks; return once taken
  task automatic send_beat(input cmd_t op, input logic [PRIO_BITS-1:0] p,
                           input logic [TAG_BITS-1:0] t, input logic typed,
                           input queue_result_t res);
    int gaps;
    gaps = 0;
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gaps++;
    if (gaps > 0) begin
      start <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    start        <= 1'b1;
    cmd          <= op;
    priority_req <= p;
    msg_tag      <= t;
    row_typed    <= typed;
    row_res      <= res;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  // Hold off the sender until every result beat is back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (got_count < sent_count) @(posedge clk);
  endtask

  initial begin
    int phase_idle [N_PHASES];
    int ph;
    int k;
    int push_pct;
    int base;
    logic narrow;
    cmd_t op;
    logic [PRIO_BITS-1:0] p;
    logic [TAG_BITS-1:0] t;

    phase_idle = '{0, 73, 0, 28};
    push_pct = 50;
    base = 0;
    narrow = 1'b0;

    // hold reset, then release it
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: empty, extremes, equal priorities, fill to full
    for (k = 0; k < N_DIRECTED; k++)
      send_beat(directed_rows[k].op, directed_rows[k].prio, directed_rows[k].tag,
                directed_rows[k].typed, directed_rows[k].res);
    drain_results();

    // random traffic; push bias swings the fill level between empty and full
    for (ph = 0; ph < N_PHASES; ph++) begin
      idle_pct = phase_idle[ph];
      for (k = 0; k < PHASE_BEATS; k++) begin
        if (k % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
          endcase
          narrow = 1'($urandom_range(0, 1));
          base   = $urandom_range(0, 14);
        end
        op = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        // narrow bands of priority stress arrival order among equals
        p = narrow ? PRIO_BITS'(base + $urandom_range(0, 1))
                   : PRIO_BITS'($urandom_range(0, 15));
        case ($urandom_range(0, 15))
          0:       t = '0;
          1:       t = '1;
          default: t = TAG_BITS'($urandom);
        endcase
        send_beat(op, p, t, 1'b0, '0);
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatch_count == 0)
      $display("sorted_priority_queue_core: match");
    else
      $display("sorted_priority_queue_core: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue_core.sv
tb/sv/tb_sorted_priority_queue_core.sv
